@@ design/buddy_page_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL.
// Each macro expands to one labeled concurrent assertion on clk_i, idle in reset.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, constants and controller/datapath interface of the buddy allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int unsigned MaxOrder  = 11;
  localparam int unsigned PageCount = 65536;
  localparam int unsigned PageW     = $clog2(PageCount);
  localparam int unsigned LinkW     = PageW + 1;
  localparam int unsigned OrderW    = 4;
  localparam int unsigned CountW    = 17;
  localparam int unsigned LvlIdxW   = $clog2(MaxOrder);

  localparam logic [LinkW-1:0]  NilLink   = LinkW'(PageCount);
  localparam logic [CountW-1:0] FreeMax   = {CountW{1'b1}};
  localparam logic [CountW-1:0] TotalRst  = CountW'(65536);
  localparam logic              ReqAlloc  = 1'b0;
  localparam logic              ReqFree   = 1'b1;

  typedef enum logic [1:0] {
    StatDone    = 2'd0,
    StatNoSpace = 2'd1,
    StatRange   = 2'd2
  } status_e;

  typedef struct packed {
    logic              req_type;
    logic [OrderW-1:0] order;
    logic [PageW-1:0]  page_offset;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PageW-1:0]  block_offset;
    logic [CountW-1:0] free_pages;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic fail;
    logic take;
    logic rd;
    logic unlink;
    logic merge;
    logic split;
    logic set_push;
    logic push1;
    logic push2;
    logic alloc_fin;
    logic free_fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic    clear_last;
    logic    req_free;
    status_e chk_code;
    logic    split_more;
    logic    loop_stop;
    logic    buddy_match;
    logic    out_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ design/buddy_page_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator with per-order LIFO free lists over 64K pages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o carries one allocate or free request
//   per transaction; output channel out_valid_o/out_stall_i returns exactly one
//   result (status, block offset, free page count) per request, in order.
//   cfg_we_i/cfg_wdata_i write the managed page count; write it only while idle.
// Sequencing, one request at a time through a single state sequencer:
//   allocate: check, read and unlink the head of the lowest fitting list, then
//     one split per level (order found minus requested), pushing the upper half.
//   free: while the buddy is a free block of the same order, unlink and merge;
//     then push the merged block. A refused request goes straight to the result.
//   Each merge level costs a read of the metadata/link memories and a link update.
// Reset: all free lists empty, free count zero, managed page count 65536. A
//   clearing pass over all 65536 pages then zeroes the free-head flags; in_stall_o
//   stays high meanwhile (configuration writes are taken).
// Stall: a result waits in the output register while out_stall_i is high; the
//   next request is accepted meanwhile and holds only at its own completion.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire bpa_pkg::req_t              in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output bpa_pkg::rsp_t                   out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [bpa_pkg::CountW-1:0] cfg_wdata_i
);

  `include "buddy_page_allocator_assert.svh"

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpa_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `BPA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                   "request accepted but input not stalled next cycle")
  `BPA_ASSERT_SAME(a_no_overwrite, cmd.emit, !(out_valid_o && out_stall_i),
                   "result emitted over a held transaction")
  `BPA_ASSERT_SAME(a_fail_offset_zero,
                   out_valid_o && (out_data_o.status != bpa_pkg::StatDone),
                   out_data_o.block_offset == '0,
                   "failed request reports a nonzero offset")

endmodule

`default_nettype wire

@@ design/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for clearing, allocate split walk and free merge walk.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] SClear   = 4'd0;
  localparam logic [3:0] SIdle    = 4'd1;
  localparam logic [3:0] SCheck   = 4'd2;
  localparam logic [3:0] SARead   = 4'd3;
  localparam logic [3:0] SAUnlink = 4'd4;
  localparam logic [3:0] SSplit   = 4'd5;
  localparam logic [3:0] SPush1   = 4'd6;
  localparam logic [3:0] SPush2   = 4'd7;
  localparam logic [3:0] SFLoop   = 4'd8;
  localparam logic [3:0] SFTest   = 4'd9;
  localparam logic [3:0] SDone    = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SCheck;
        end
      end
      SCheck: begin
        priority if (sts_i.chk_code != bpa_pkg::StatDone) begin
          cmd_o.fail = 1'b1;
          state_d    = SDone;
        end else if (sts_i.req_free) begin
          state_d = SFLoop;
        end else begin
          cmd_o.take = 1'b1;
          state_d    = SARead;
        end
      end
      SARead: begin
        cmd_o.rd = 1'b1;
        state_d  = SAUnlink;
      end
      SAUnlink: begin
        cmd_o.unlink = 1'b1;
        state_d      = SSplit;
      end
      SSplit: begin
        if (sts_i.split_more) begin
          cmd_o.split = 1'b1;
          state_d     = SPush1;
        end else begin
          cmd_o.alloc_fin = 1'b1;
          state_d         = SDone;
        end
      end
      SPush1: begin
        cmd_o.push1 = 1'b1;
        state_d     = SPush2;
      end
      SPush2: begin
        cmd_o.push2 = 1'b1;
        if (sts_i.req_free) begin
          cmd_o.free_fin = 1'b1;
          state_d        = SDone;
        end else begin
          state_d = SSplit;
        end
      end
      SFLoop: begin
        if (sts_i.loop_stop) begin
          cmd_o.set_push = 1'b1;
          state_d        = SPush1;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = SFTest;
        end
      end
      SFTest: begin
        if (sts_i.buddy_match) begin
          cmd_o.unlink = 1'b1;
          cmd_o.merge  = 1'b1;
          state_d      = SFLoop;
        end else begin
          cmd_o.set_push = 1'b1;
          state_d        = SPush1;
        end
      end
      SDone: begin
        // hold the result until the output register frees up
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/bpa_dpath.sv @@
// ----------------------------------------------------------------------------
// bpa_dpath
// Block metadata and link memories, list heads, free count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bpa_pkg::req_t                 in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bpa_pkg::CountW-1:0]    cfg_wdata_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output bpa_pkg::rsp_t                      out_data_o,
  input  wire bpa_pkg::cmd_t                 cmd_i,
  output bpa_pkg::sts_t                      sts_o
);

  localparam int unsigned PageW  = bpa_pkg::PageW;
  localparam int unsigned LinkW  = bpa_pkg::LinkW;
  localparam int unsigned OrderW = bpa_pkg::OrderW;
  localparam int unsigned CountW = bpa_pkg::CountW;
  localparam int unsigned MetaW  = OrderW + 1;

  // metadata entry: free-head flag over block order
  logic [MetaW-1:0] meta_mem [bpa_pkg::PageCount];
  logic [LinkW-1:0] next_mem [bpa_pkg::PageCount];
  logic [LinkW-1:0] prev_mem [bpa_pkg::PageCount];

  logic [LinkW-1:0]  head_q [bpa_pkg::MaxOrder];
  logic [CountW-1:0] total_q, free_q;
  logic              req_free_q;
  logic [OrderW-1:0] ord_q, lvl_q, push_ord_q;
  logic [PageW-1:0]  pg_q, push_pg_q, res_q, clr_q;
  bpa_pkg::status_e  stat_q;
  logic              out_valid_q;
  bpa_pkg::rsp_t     out_q;
  logic [MetaW-1:0]  meta_rd_q;
  logic [LinkW-1:0]  next_rd_q, prev_rd_q;

  logic [CountW-1:0] lim, ord_bit, off_end;
  logic [CountW:0]   par_end, free_sum;
  logic              ord_ok, found;
  logic [bpa_pkg::LvlIdxW-1:0] found_idx;
  logic [PageW-1:0]  lvl_bit, buddy, parent, node, split_pg;
  logic [OrderW-1:0] lvl_inc, lvl_dec;
  logic [LinkW-1:0]  old_head;
  bpa_pkg::status_e  chk;

  logic             meta_we, next_we, prev_we;
  logic [PageW-1:0] meta_wa, next_wa, prev_wa;
  logic [MetaW-1:0] meta_wd;
  logic [LinkW-1:0] next_wd, prev_wd;

  assign lim      = (total_q > CountW'(bpa_pkg::PageCount)) ?
                    CountW'(bpa_pkg::PageCount) : total_q;
  assign ord_ok   = (ord_q < OrderW'(bpa_pkg::MaxOrder));
  assign ord_bit  = CountW'(1) << ord_q;
  assign off_end  = {1'b0, pg_q} + ord_bit;
  assign lvl_bit  = PageW'(1) << lvl_q;
  assign buddy    = pg_q ^ lvl_bit;
  assign parent   = pg_q & ~lvl_bit;
  assign lvl_inc  = lvl_q + OrderW'(1);
  assign lvl_dec  = lvl_q - OrderW'(1);
  assign par_end  = {2'b00, parent} + ((CountW + 1)'(1) << lvl_inc);
  assign split_pg = pg_q + (PageW'(1) << lvl_dec);
  assign node     = req_free_q ? buddy : pg_q;
  assign old_head = head_q[push_ord_q[bpa_pkg::LvlIdxW-1:0]];
  assign free_sum = {1'b0, free_q} + {1'b0, ord_bit};

  // lowest non-empty list at or above the requested order
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int k = 0; k < bpa_pkg::MaxOrder; k++) begin
      if (!found && (OrderW'(k) >= ord_q) && !head_q[k][PageW]) begin
        found     = 1'b1;
        found_idx = bpa_pkg::LvlIdxW'(k);
      end
    end
  end

  always_comb begin
    priority if (!ord_ok) begin
      chk = bpa_pkg::StatRange;
    end else if (req_free_q) begin
      chk = (off_end > lim) ? bpa_pkg::StatRange : bpa_pkg::StatDone;
    end else if ((free_q < ord_bit) || !found) begin
      chk = bpa_pkg::StatNoSpace;
    end else begin
      chk = bpa_pkg::StatDone;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.clear_last  = &clr_q;
    sts_o.req_free    = req_free_q;
    sts_o.chk_code    = chk;
    sts_o.split_more  = (lvl_q > ord_q);
    sts_o.loop_stop   = (lvl_inc >= OrderW'(bpa_pkg::MaxOrder)) || (par_end > {1'b0, lim});
    sts_o.buddy_match = meta_rd_q[OrderW] && (meta_rd_q[OrderW-1:0] == lvl_q);
    sts_o.out_busy    = out_valid_q && out_stall_i;
  end

  // memory write steering
  always_comb begin
    meta_we = 1'b0;
    meta_wa = '0;
    meta_wd = '0;
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    priority if (cmd_i.clear) begin
      meta_we = 1'b1;
      meta_wa = clr_q;
    end else if (cmd_i.unlink) begin
      meta_we = 1'b1;
      meta_wa = node;
      meta_wd = {1'b0, (req_free_q ? lvl_q : ord_q)};
      next_we = !prev_rd_q[PageW];
      next_wa = prev_rd_q[PageW-1:0];
      next_wd = next_rd_q;
      prev_we = !next_rd_q[PageW];
      prev_wa = next_rd_q[PageW-1:0];
      prev_wd = prev_rd_q;
    end else if (cmd_i.push1) begin
      meta_we = 1'b1;
      meta_wa = push_pg_q;
      meta_wd = {1'b1, push_ord_q};
      next_we = 1'b1;
      next_wa = push_pg_q;
      next_wd = old_head;
      prev_we = 1'b1;
      prev_wa = push_pg_q;
      prev_wd = bpa_pkg::NilLink;
    end else if (cmd_i.push2) begin
      prev_we = !old_head[PageW];
      prev_wa = old_head[PageW-1:0];
      prev_wd = {1'b0, push_pg_q};
    end else begin
      meta_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd_i.rd) begin
      meta_rd_q <= meta_mem[node];
      next_rd_q <= next_mem[node];
      prev_rd_q <= prev_mem[node];
    end
  end

  // control state: list heads, counts, config, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bpa_pkg::MaxOrder; k++) head_q[k] <= bpa_pkg::NilLink;
      total_q     <= bpa_pkg::TotalRst;
      free_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) total_q <= cfg_wdata_i;
      if (cmd_i.clear) clr_q <= clr_q + PageW'(1);
      if (cmd_i.unlink && prev_rd_q[PageW]) begin
        head_q[lvl_q[bpa_pkg::LvlIdxW-1:0]] <= next_rd_q;
      end
      if (cmd_i.push2) head_q[push_ord_q[bpa_pkg::LvlIdxW-1:0]] <= {1'b0, push_pg_q};
      if (cmd_i.alloc_fin) free_q <= free_q - ord_bit;
      if (cmd_i.free_fin) begin
        free_q <= (free_sum > {1'b0, bpa_pkg::FreeMax}) ? bpa_pkg::FreeMax
                                                        : free_sum[CountW-1:0];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_free_q <= in_data_i.req_type;
      ord_q      <= in_data_i.order;
      lvl_q      <= in_data_i.order;
      pg_q       <= in_data_i.page_offset;
    end
    if (cmd_i.take) begin
      pg_q  <= head_q[found_idx][PageW-1:0];
      lvl_q <= OrderW'(found_idx);
    end
    if (cmd_i.merge) begin
      pg_q  <= parent;
      lvl_q <= lvl_inc;
    end
    if (cmd_i.split) begin
      lvl_q      <= lvl_dec;
      push_pg_q  <= split_pg;
      push_ord_q <= lvl_dec;
    end
    if (cmd_i.set_push) begin
      push_pg_q  <= pg_q;
      push_ord_q <= lvl_q;
    end
    if (cmd_i.fail) begin
      stat_q <= chk;
      res_q  <= '0;
    end
    if (cmd_i.alloc_fin || cmd_i.free_fin) begin
      stat_q <= bpa_pkg::StatDone;
      res_q  <= pg_q;
    end
    if (cmd_i.emit) begin
      out_q.status       <= stat_q;
      out_q.block_offset <= res_q;
      out_q.free_pages   <= free_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
